@@ sv/quantized_value_requantizer_top_macros.svh @@
// Assertion macros shared by the requantizer checker.
`ifndef QUANTIZED_VALUE_REQUANTIZER_TOP_MACROS_SVH
`define QUANTIZED_VALUE_REQUANTIZER_TOP_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define QVR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("requantizer check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define QVR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("requantizer check failed");

`endif

@@ sv/qvr_pkg.sv @@
// Package with the types and constants of the quantized value requantizer.
package qvr_pkg;

  // Element format codes, shared by the source and destination registers.
  localparam logic [1:0] FMT_S8  = 2'd0;
  localparam logic [1:0] FMT_U8  = 2'd1;
  localparam logic [1:0] FMT_S16 = 2'd2;
  localparam logic [1:0] FMT_U16 = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SCALE_RATIO   = 2'd0;
  localparam logic [1:0] CFG_OFFSET_TERM   = 2'd1;
  localparam logic [1:0] CFG_SOURCE_FORMAT = 2'd2;
  localparam logic [1:0] CFG_DEST_FORMAT   = 2'd3;

  localparam int unsigned CfgDataW = 41;
  localparam int unsigned FracBits = 16;

  // Input transaction payload.
  typedef struct packed {
    logic [15:0] raw_element;
    logic        final_element;
  } qvr_in_t;

  // Output transaction payload.
  typedef struct packed {
    logic [15:0] converted_element;
    logic        written;
    logic        final_result;
  } qvr_out_t;

  // Current register contents, handed to the datapath.
  typedef struct packed {
    logic [31:0]        scale_ratio;
    logic signed [40:0] offset_term;
    logic [1:0]         source_format;
    logic [1:0]         dest_format;
  } qvr_cfg_t;

endpackage

@@ sv/qvr_cfg.sv @@
// Configuration register bank of the requantizer.
module qvr_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [1:0]                          cfg_idx_i,
  input  logic [qvr_pkg::CfgDataW-1:0]        cfg_data_i,
  output qvr_pkg::qvr_cfg_t                   cfg_o
);
  import qvr_pkg::*;

  qvr_cfg_t cfg_q, cfg_d;

  // Decode the write index and update the addressed register.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SCALE_RATIO:   cfg_d.scale_ratio   = cfg_data_i[31:0];
        CFG_OFFSET_TERM:   cfg_d.offset_term   = $signed(cfg_data_i[40:0]);
        CFG_SOURCE_FORMAT: cfg_d.source_format = cfg_data_i[1:0];
        CFG_DEST_FORMAT:   cfg_d.dest_format   = cfg_data_i[1:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  // Registers come up as unity gain, zero offset, signed 8-bit both ways.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.scale_ratio   <= 32'd65536;
      cfg_q.offset_term   <= '0;
      cfg_q.source_format <= FMT_S8;
      cfg_q.dest_format   <= FMT_S8;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ sv/qvr_pipe.sv @@
// Four-stage requantization datapath: load, multiply, add offset, round and saturate.
module qvr_pipe (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  qvr_pkg::qvr_cfg_t   cfg_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  qvr_pkg::qvr_in_t    in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output qvr_pkg::qvr_out_t   out_data_o
);
  import qvr_pkg::*;

  localparam logic signed [34:0] S8Lo  = -35'sd128;
  localparam logic signed [34:0] S8Hi  = 35'sd127;
  localparam logic signed [34:0] S16Lo = -35'sd32768;
  localparam logic signed [34:0] S16Hi = 35'sd32767;
  localparam logic signed [34:0] ULo   = 35'sd0;
  localparam logic signed [34:0] U8Hi  = 35'sd255;
  localparam logic signed [34:0] U16Hi = 35'sd65535;

  // Stage valid bits and the ready chain that lets full stages advance.
  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4       = !v4_q || out_ready_i;
  assign rdy3       = !v3_q || rdy4;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // Stage 1: widen the source element to a signed 17-bit value.
  logic signed [16:0] x_d, x_q;
  logic               wr_d, wr1_q, fin1_q;
  logic               src_signed;

  always_comb begin
    src_signed = !cfg_i.source_format[0];
    wr_d       = cfg_i.source_format[0] == cfg_i.dest_format[0];
    if (cfg_i.source_format[1]) begin
      x_d = $signed({src_signed & in_data_i.raw_element[15], in_data_i.raw_element});
    end else begin
      x_d = $signed({{9{src_signed & in_data_i.raw_element[7]}},
                     in_data_i.raw_element[7:0]});
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      x_q    <= x_d;
      wr1_q  <= wr_d;
      fin1_q <= in_data_i.final_element;
    end
  end

  // Stage 2: multiply by the unsigned Q16.16 gain.
  logic signed [49:0] prod_q;
  logic               wr2_q, fin2_q;

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      prod_q <= x_q * $signed({1'b0, cfg_i.scale_ratio});
      wr2_q  <= wr1_q;
      fin2_q <= fin1_q;
    end
  end

  // Stage 3: add the signed Q24.16 offset.
  logic signed [50:0] sum_q;
  logic               wr3_q, fin3_q;

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      sum_q  <= {prod_q[49], prod_q} + {{10{cfg_i.offset_term[40]}}, cfg_i.offset_term};
      wr3_q  <= wr2_q;
      fin3_q <= fin2_q;
    end
  end

  // Stage 4: truncate toward zero, then clamp to the destination range.
  logic signed [34:0] q_floor, q_trunc, lo, hi, q_sat;
  logic               round_up;
  qvr_out_t           out_d, out_q;

  always_comb begin
    q_floor  = sum_q[50:FracBits];
    round_up = sum_q[50] && (|sum_q[FracBits-1:0]);
    q_trunc  = q_floor + $signed({34'd0, round_up});
    unique case (cfg_i.dest_format)
      FMT_S8:  begin lo = S8Lo;  hi = S8Hi;  end
      FMT_U8:  begin lo = ULo;   hi = U8Hi;  end
      FMT_S16: begin lo = S16Lo; hi = S16Hi; end
      FMT_U16: begin lo = ULo;   hi = U16Hi; end
      default: begin lo = ULo;   hi = U16Hi; end
    endcase
    if (q_trunc < lo) begin
      q_sat = lo;
    end else if (q_trunc > hi) begin
      q_sat = hi;
    end else begin
      q_sat = q_trunc;
    end
    out_d.written      = wr3_q;
    out_d.final_result = fin3_q;
    if (!wr3_q) begin
      out_d.converted_element = 16'd0;
    end else if (cfg_i.dest_format[1]) begin
      out_d.converted_element = q_sat[15:0];
    end else begin
      out_d.converted_element = {8'd0, q_sat[7:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy4 && v3_q) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = v4_q;
  assign out_data_o  = out_q;

endmodule

@@ sv/quantized_value_requantizer_top.sv @@
// Top level of the quantized value requantizer.
//
// Usage: each input transaction carries one raw 8- or 16-bit element and a
// last-element flag; each output transaction carries the requantized element,
// a written flag and the copied last flag. The element is mapped through
// scale_ratio * x + offset_term, truncated toward zero and saturated to the
// destination format. A format pair of mixed signedness yields a zero element
// with written low.
// The four register stages are load, one 17x33 multiply, one 51-bit offset
// add, and one round-and-clamp stage that ends in the output register. The
// pipeline takes one element per cycle while the receiver is not stalling.
// Configuration writes go through the write port and must only happen while
// no transaction is in flight.
// Reset empties all four stages and loads unity gain, zero offset and signed
// 8-bit formats. When the receiver stalls, full stages hold their data and
// in_ready_o drops only once every stage is occupied; nothing is lost.
module quantized_value_requantizer_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [qvr_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  qvr_pkg::qvr_in_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output qvr_pkg::qvr_out_t             out_data_o
);
  import qvr_pkg::*;

  qvr_cfg_t cfg;

  // Register bank.
  qvr_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Datapath.
  qvr_pipe u_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ sv/qvr_checker.sv @@
// Port-level checker for the requantizer, bound to the top level.
`include "quantized_value_requantizer_top_macros.svh"

module qvr_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_ready_o,
  input  logic                          out_valid_o,
  input  logic                          out_ready_i,
  input  qvr_pkg::qvr_out_t             out_data_o
);
  import qvr_pkg::*;

  // A stalled output transaction keeps its payload.
  `QVR_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))

  // An unsupported format pair always delivers a zero element.
  `QVR_ASSERT_NOW(a_unwritten_zero, out_valid_o && !out_data_o.written, out_data_o.converted_element == 16'd0)

  // Input back-pressure only appears once the output itself is stalled.
  `QVR_ASSERT_NOW(a_ready_cause, !in_ready_o, out_valid_o && !out_ready_i)

endmodule

bind quantized_value_requantizer_top qvr_checker u_qvr_checker (.*);

@@ tb/quantized_value_requantizer_top_tb.sv @@
// Self-checking testbench for the quantized value requantizer top level.
`timescale 1ns / 100ps

module quantized_value_requantizer_top_tb;
  import qvr_pkg::*;

  // Tracks register contents, predicts each requantized element and compares results.
  class requant_scoreboard;
    logic [31:0]        scale_ratio;
    logic signed [40:0] offset_term;
    logic [1:0]         source_format;
    logic [1:0]         dest_format;
    qvr_out_t           expected_q[$];
    int                 errors;

    function new();
      scale_ratio   = 32'h0001_0000;
      offset_term   = '0;
      source_format = FMT_S8;
      dest_format   = FMT_S8;
      errors        = 0;
    endfunction

    // Mirror one register write.
    function void set_reg(logic [1:0] idx, logic [CfgDataW-1:0] value);
      case (idx)
        CFG_SCALE_RATIO:   scale_ratio = value[31:0];
        CFG_OFFSET_TERM:   offset_term = value[40:0];
        CFG_SOURCE_FORMAT: source_format = value[1:0];
        CFG_DEST_FORMAT:   dest_format = value[1:0];
        default: ;
      endcase
    endfunction

    // Affine map, truncation toward zero and saturation to the destination.
    function qvr_out_t requantize(qvr_in_t item);
      qvr_out_t res;
      longint   x;
      longint   gain;
      longint   bias;
      longint   sum;
      longint   q;
      longint   lo;
      longint   hi;
      res = '0;
      res.final_result = item.final_element;
      if (source_format[0] == dest_format[0]) begin
        case (source_format)
          FMT_S8:  x = $signed(item.raw_element[7:0]);
          FMT_U8:  x = item.raw_element[7:0];
          FMT_S16: x = $signed(item.raw_element);
          default: x = item.raw_element;
        endcase
        gain = scale_ratio;
        bias = offset_term;
        sum = x * gain + bias;
        if (sum < 0) begin
          q = -((-sum) >>> FracBits);
        end else begin
          q = sum >>> FracBits;
        end
        case (dest_format)
          FMT_S8: begin
            lo = -128;
            hi = 127;
          end
          FMT_U8: begin
            lo = 0;
            hi = 255;
          end
          FMT_S16: begin
            lo = -32768;
            hi = 32767;
          end
          default: begin
            lo = 0;
            hi = 65535;
          end
        endcase
        if (q < lo) q = lo;
        if (q > hi) q = hi;
        res.converted_element = dest_format[1] ? q[15:0] : {8'h00, q[7:0]};
        res.written = 1'b1;
      end
      return res;
    endfunction

    // Called for every accepted input transaction.
    function void note_input(qvr_in_t item);
      expected_q.push_back(requantize(item));
    endfunction

    // Called for every accepted output transaction.
    function void check_result(qvr_out_t got);
      qvr_out_t exp_res;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %h with nothing outstanding", $time, got);
        errors++;
        return;
      end
      exp_res = expected_q.pop_front();
      if (got.converted_element !== exp_res.converted_element) begin
        $display("%0t: converted_element expected %h, got %h", $time,
                 exp_res.converted_element, got.converted_element);
        errors++;
      end
      if (got.written !== exp_res.written) begin
        $display("%0t: written expected %b, got %b", $time, exp_res.written, got.written);
        errors++;
      end
      if (got.final_result !== exp_res.final_result) begin
        $display("%0t: final_result expected %b, got %b", $time,
                 exp_res.final_result, got.final_result);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [1:0]          cfg_idx = CFG_SCALE_RATIO;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  qvr_in_t             in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  qvr_out_t            out_data;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  requant_scoreboard sb = new();

  quantized_value_requantizer_top uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  always #2 clk = ~clk;

  // Receiver back-pressure, changed on the falling edge.
  always @(negedge clk) begin
    out_ready = ($urandom_range(99) >= recv_stall_pct);
  end

  // Check every output transaction at the rising edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_result(out_data);
    end
  end

  // Hard limit on the run.
  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Keep the input side quiet until every outstanding result has arrived.
  task automatic hold_until_drained();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // One register write; called on a falling edge.
  task automatic write_reg(input logic [1:0] idx, input logic [CfgDataW-1:0] value);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = value;
    sb.set_reg(idx, value);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Load all four registers once the block is idle.
  task automatic apply_config(input logic [31:0] scale, input logic signed [40:0] offset,
                              input logic [1:0] src_fmt, input logic [1:0] dst_fmt);
    hold_until_drained();
    write_reg(CFG_SCALE_RATIO, {9'd0, scale});
    write_reg(CFG_OFFSET_TERM, offset);
    write_reg(CFG_SOURCE_FORMAT, {39'd0, src_fmt});
    write_reg(CFG_DEST_FORMAT, {39'd0, dst_fmt});
  endtask

  // Send one element transaction; entered and left on a falling edge.
  task automatic send_element(input logic [15:0] raw, input logic fin);
    qvr_in_t item;
    item.raw_element   = raw;
    item.final_element = fin;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = item;
    do @(posedge clk); while (!in_ready);
    sb.note_input(item);
    @(negedge clk);
  endtask

  // Random configuration for one phase; the first phases pin the extremes.
  task automatic pick_config(input int phase);
    logic [31:0]        scale;
    logic signed [40:0] offset;
    logic [1:0]         src_fmt;
    logic [1:0]         dst_fmt;
    longint             small_off;
    case (phase)
      0: begin
        scale  = 32'hFFFF_FFFF;
        offset = 41'h0FF_FFFF_FFFF;
      end
      1: begin
        scale  = 32'h0000_0000;
        offset = 41'h100_0000_0000;
      end
      2: begin
        scale  = 32'h0001_0000;
        offset = '0;
      end
      default: begin
        case ($urandom_range(3))
          0: scale = $urandom;
          1: scale = $urandom_range(32'h0002_0000);
          2: scale = 32'h0001_0000;
          default: scale = $urandom_range(255);
        endcase
        small_off = longint'($urandom_range(32'h0200_0000)) - 64'sh0100_0000;
        case ($urandom_range(2))
          0: offset = 41'({$urandom, $urandom});
          1: offset = small_off[40:0];
          default: offset = '0;
        endcase
      end
    endcase
    src_fmt = 2'($urandom_range(3));
    dst_fmt = 2'($urandom_range(3));
    // Mostly matching signedness so that most results carry data.
    if ($urandom_range(99) < 80) dst_fmt[0] = src_fmt[0];
    apply_config(scale, offset, src_fmt, dst_fmt);
  endtask

  // Random element, with extra weight on the range edges.
  function automatic logic [15:0] pick_raw();
    logic [15:0] edges[7] = '{16'h0000, 16'h007F, 16'h0080, 16'h00FF,
                             16'h7FFF, 16'h8000, 16'hFFFF};
    if ($urandom_range(7) == 0) return edges[$urandom_range(6)];
    return 16'($urandom);
  endfunction

  initial begin
    int unsigned idle_modes[4][2] = '{'{0, 0}, '{55, 0}, '{0, 55}, '{21, 21}};
    int          items_per_phase;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: reset configuration, signed 8 to signed 8 at unity gain.
    send_element(16'h0080, 1'b0);
    send_element(16'h017F, 1'b0);
    send_element(16'h0000, 1'b1);

    // Gain 1.5, offset -0.5: high byte ignored, negative truncation, saturation.
    apply_config(32'h0001_8000, -41'sd32768, FMT_S8, FMT_S8);
    send_element(16'h0001, 1'b0);
    send_element(16'hFF01, 1'b0);
    send_element(16'h00FF, 1'b0);
    send_element(16'hAAFD, 1'b0);
    send_element(16'h007F, 1'b0);
    send_element(16'h0080, 1'b0);

    // Offset -0.25: a negative fraction truncates to zero, not to minus one.
    apply_config(32'h0001_0000, -41'sd16384, FMT_S16, FMT_S16);
    send_element(16'h0000, 1'b0);
    send_element(16'hFFFF, 1'b0);

    // Wide unsigned source into a narrow unsigned destination.
    apply_config(32'h0001_0000, '0, FMT_U16, FMT_U8);
    send_element(16'hFFFF, 1'b0);
    send_element(16'h0100, 1'b0);
    send_element(16'h00FF, 1'b0);
    send_element(16'h0000, 1'b0);

    // Maximum gain on a narrow unsigned source.
    apply_config(32'hFFFF_FFFF, '0, FMT_U8, FMT_U16);
    send_element(16'h00FF, 1'b0);
    send_element(16'hFF00, 1'b0);

    // Mixed signedness produces no element.
    apply_config(32'h0001_0000, '0, FMT_S16, FMT_U16);
    send_element(16'h1234, 1'b1);
    apply_config(32'h0001_0000, '0, FMT_U8, FMT_S8);
    send_element(16'h00AA, 1'b0);

    // Maximum gain with the most negative offset, saturating both ways.
    apply_config(32'hFFFF_FFFF, 41'h100_0000_0000, FMT_S16, FMT_S16);
    send_element(16'h8000, 1'b0);
    send_element(16'h7FFF, 1'b0);
    send_element(16'h0000, 1'b1);

    // Random phases, each with its own configuration and idling pattern.
    for (int phase = 0; phase < 8; phase++) begin
      pick_config(phase);
      send_idle_pct  = idle_modes[phase % 4][0];
      recv_stall_pct = idle_modes[phase % 4][1];
      items_per_phase = 100;
      for (int i = 0; i < items_per_phase; i++) begin
        // Midway through, let the pipeline run completely dry.
        if (i == items_per_phase / 2) hold_until_drained();
        send_element(pick_raw(), (i == items_per_phase - 1) || ($urandom_range(15) == 0));
      end
    end

    // Drain and give the pipeline time to show any stray result.
    hold_until_drained();
    recv_stall_pct = 0;
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
